// File: rtl/hrc_pkg.sv
// Shared constants and types for the HLS to RGB converter.
`timescale 1ns / 1ps

package hrc_pkg;

	localparam int FRAC_BITS_DEF = 12;
	localparam int BYTE_W        = 8;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_TOP,
		SEG_FALL,
		SEG_BOTTOM
	} seg_t;

endpackage

// File: rtl/hrc_in_if.sv
// Input channel: one hue, lightness, saturation item per handshake.
`timescale 1ns / 1ps

interface hrc_in_if #(
	parameter int FRAC_BITS = hrc_pkg::FRAC_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] hue;
	logic [FRAC_BITS:0]   lightness;
	logic [FRAC_BITS:0]   saturation;

	modport source (output valid, output hue, output lightness, output saturation,
		input ready);
	modport sink (input valid, input hue, input lightness, input saturation,
		output ready);
endinterface

// File: rtl/hrc_out_if.sv
// Output channel: one red, green, blue item per handshake.
`timescale 1ns / 1ps

interface hrc_out_if;
	logic                           valid;
	logic                           ready;
	logic [hrc_pkg::BYTE_W-1:0]     red;
	logic [hrc_pkg::BYTE_W-1:0]     green;
	logic [hrc_pkg::BYTE_W-1:0]     blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/hrc_level.sv
// Two-level computation: clamp inputs, form m2 and m1, hand on m1 and span.
`timescale 1ns / 1ps

module hrc_level #(
	parameter int FRAC_BITS = hrc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] hue,
	input  logic [FRAC_BITS:0]   lightness,
	input  logic [FRAC_BITS:0]   saturation,
	output logic [FRAC_BITS-1:0] hue_s2,
	output logic [FRAC_BITS:0]   m1_s2,
	output logic [FRAC_BITS:0]   span_s2
);
	localparam int W = FRAC_BITS;
	localparam logic [W:0] ONE  = (W+1)'(1) << W;
	localparam logic [W:0] HALF = (W+1)'(1) << (W-1);

	logic [W:0]     l_c, s_c;
	logic [W+1:0]   mul_b;
	logic           low_half;

	logic [W-1:0]   hue_s1;
	logic [W:0]     l_s1, s_s1;
	logic           low_half_s1;
	logic [2*W+2:0] prod_s1;

	logic [W+1:0]   q;
	logic [W+1:0]   m2_wide;
	logic [W:0]     m2;
	logic [W+1:0]   m1_wide;
	logic [W:0]     m1;

	// saturate lightness and saturation to 1.0
	always_comb begin
		l_c      = (lightness > ONE) ? ONE : lightness;
		s_c      = (saturation > ONE) ? ONE : saturation;
		low_half = (l_c <= HALF);
		mul_b    = low_half ? ({1'b0, ONE} + {1'b0, s_c}) : {1'b0, s_c};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1      <= hue;
			l_s1        <= l_c;
			s_s1        <= s_c;
			low_half_s1 <= low_half;
			prod_s1     <= (2*W+3)'(l_c) * (2*W+3)'(mul_b);
		end
	end

	always_comb begin
		q       = prod_s1[2*W+1:W];
		m2_wide = low_half_s1 ? q : ({1'b0, l_s1} + {1'b0, s_s1} - q);
		m2      = m2_wide[W:0];
		m1_wide = {l_s1, 1'b0} - {1'b0, m2};
		m1      = m1_wide[W:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2  <= hue_s1;
			m1_s2   <= m1;
			span_s2 <= m2 - m1;
		end
	end

endmodule

// File: rtl/hrc_channel.sv
// One color channel: hue segment, interpolation multiply, clamp and scale to a byte.
`timescale 1ns / 1ps

module hrc_channel #(
	parameter int FRAC_BITS = hrc_pkg::FRAC_BITS_DEF,
	parameter logic [FRAC_BITS-1:0] HUE_OFS = '0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [FRAC_BITS-1:0]        hue,
	input  logic [FRAC_BITS:0]          m1,
	input  logic [FRAC_BITS:0]          span,
	output logic [hrc_pkg::BYTE_W-1:0]  level_s6
);
	localparam int W = FRAC_BITS;
	localparam int ONE_I = 1 << W;
	localparam int SIXTH_I = (ONE_I + 3) / 6;
	localparam int HALF_I = ONE_I / 2;
	localparam int TWO_THIRDS_I = (4 * ONE_I + 3) / 6;
	localparam logic [W-1:0] SIXTH = W'(SIXTH_I);
	localparam logic [W-1:0] HALF = W'(HALF_I);
	localparam logic [W-1:0] TWO_THIRDS = W'(TWO_THIRDS_I);
	localparam logic [W:0] ONE = (W+1)'(ONE_I);
	localparam int BW = hrc_pkg::BYTE_W;

	logic [W-1:0]         h;
	logic [W-1:0]         fall_ofs;
	logic [W+1:0]         t_wide;
	hrc_pkg::seg_t        seg;

	hrc_pkg::seg_t        seg_s3, seg_s4;
	logic [W:0]           t_s3;
	logic [W:0]           m1_s3, span_s3;
	logic [W:0]           m1_s4, m2_s4;
	logic [2*W+1:0]       prod_s4;
	logic [W+1:0]         c_wide;
	logic [W:0]           c_s5;
	logic [W+BW:0]        scaled;
	logic [BW:0]          byte_w;

	// pick the hue segment and the interpolation weight
	always_comb begin
		h        = hue + HUE_OFS;
		fall_ofs = TWO_THIRDS - h;
		t_wide   = '0;
		if (h < SIXTH) begin
			seg    = hrc_pkg::SEG_RISE;
			t_wide = {h, 2'b00} + {1'b0, h, 1'b0};
		end else if (h < HALF) begin
			seg = hrc_pkg::SEG_TOP;
		end else if (h < TWO_THIRDS) begin
			seg    = hrc_pkg::SEG_FALL;
			t_wide = {fall_ofs, 2'b00} + {1'b0, fall_ofs, 1'b0};
		end else begin
			seg = hrc_pkg::SEG_BOTTOM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s3  <= seg;
			t_s3    <= t_wide[W:0];
			m1_s3   <= m1;
			span_s3 <= span;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s4  <= seg_s3;
			m1_s4   <= m1_s3;
			m2_s4   <= m1_s3 + span_s3;
			prod_s4 <= (2*W+2)'(span_s3) * (2*W+2)'(t_s3);
		end
	end

	always_comb begin
		unique case (seg_s4)
			hrc_pkg::SEG_RISE,
			hrc_pkg::SEG_FALL:   c_wide = {1'b0, m1_s4} + prod_s4[2*W+1:W];
			hrc_pkg::SEG_TOP:    c_wide = {1'b0, m2_s4};
			hrc_pkg::SEG_BOTTOM: c_wide = {1'b0, m1_s4};
			default:             c_wide = {1'b0, m1_s4};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= (c_wide > {1'b0, ONE}) ? ONE : c_wide[W:0];
		end
	end

	// times 255 as shift and subtract
	always_comb begin
		scaled = {c_s5, {BW{1'b0}}} - (W+BW+1)'(c_s5);
		byte_w = scaled[W+BW:W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s6 <= (byte_w > (BW+1)'(255)) ? BW'(255) : byte_w[BW-1:0];
		end
	end

endmodule

// File: rtl/hls_to_rgb_converter.sv
// Top level of the HLS to RGB converter: six-stage pipeline with valid chain.
`timescale 1ns / 1ps
//
//  channel   role   payload                              handshake
//  pix_in    sink   hue, lightness, saturation (Q)       valid / ready
//  pix_out   source red, green, blue (8 bit each)        valid / ready
//
//  One item enters every clock unless pix_out stalls; the six register stages
//  (operand multiply, m1/m2, hue segment, interpolation multiply, clamp, byte
//  scaling) lie between input and output. All stages advance together: a stall
//  at pix_out holds every stage while the last one holds a result, so bubbles
//  inside the pipe stay where they are. arst_n clears only the valid chain; data
//  registers hold whatever they had.
//
module hls_to_rgb_converter #(
	parameter int FRAC_BITS = hrc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hrc_in_if.sink    pix_in,
	hrc_out_if.source pix_out
);
	localparam int STAGES = 6;
	localparam int ONE_I = 1 << FRAC_BITS;
	localparam int THIRD_I = (2 * ONE_I + 3) / 6;
	localparam logic [FRAC_BITS-1:0] OFS_RED  = FRAC_BITS'(THIRD_I);
	localparam logic [FRAC_BITS-1:0] OFS_GRN  = '0;
	localparam logic [FRAC_BITS-1:0] OFS_BLUE = FRAC_BITS'(ONE_I - THIRD_I);

	logic                 advance;
	logic [STAGES-1:0]    valid_q;
	logic [FRAC_BITS-1:0] hue_s2;
	logic [FRAC_BITS:0]   m1_s2;
	logic [FRAC_BITS:0]   span_s2;

	// advance whenever the last stage is empty or its result is taken
	assign advance      = !valid_q[STAGES-1] || pix_out.ready;
	assign pix_in.ready = advance;

	// shift valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[STAGES-2:0], pix_in.valid};
		end
	end

	hrc_level #(.FRAC_BITS(FRAC_BITS)) u_level (
		.clk        (clk),
		.en         (advance),
		.hue        (pix_in.hue),
		.lightness  (pix_in.lightness),
		.saturation (pix_in.saturation),
		.hue_s2     (hue_s2),
		.m1_s2      (m1_s2),
		.span_s2    (span_s2)
	);

	// red leads hue by a third of a turn, blue trails by a third
	hrc_channel #(.FRAC_BITS(FRAC_BITS), .HUE_OFS(OFS_RED)) u_red (
		.clk      (clk),
		.en       (advance),
		.hue      (hue_s2),
		.m1       (m1_s2),
		.span     (span_s2),
		.level_s6 (pix_out.red)
	);

	hrc_channel #(.FRAC_BITS(FRAC_BITS), .HUE_OFS(OFS_GRN)) u_green (
		.clk      (clk),
		.en       (advance),
		.hue      (hue_s2),
		.m1       (m1_s2),
		.span     (span_s2),
		.level_s6 (pix_out.green)
	);

	hrc_channel #(.FRAC_BITS(FRAC_BITS), .HUE_OFS(OFS_BLUE)) u_blue (
		.clk      (clk),
		.en       (advance),
		.hue      (hue_s2),
		.m1       (m1_s2),
		.span     (span_s2),
		.level_s6 (pix_out.blue)
	);

	assign pix_out.valid = valid_q[STAGES-1];

endmodule

// File: sim/tb.sv
// Self-checking testbench for hls_to_rgb_converter: directed and random HLS items.
`timescale 1ns / 1ps

module tb;

	localparam int FRAC_BITS = hrc_pkg::FRAC_BITS_DEF;
	localparam int BYTE_W    = hrc_pkg::BYTE_W;

	// Q-format landmarks of the hue circle and the unit range
	localparam longint unsigned ONE_Q        = 64'd1 << FRAC_BITS;
	localparam longint unsigned HALF_Q       = ONE_Q >> 1;
	localparam longint unsigned THIRD_Q      = (2 * ONE_Q + 3) / 6;
	localparam longint unsigned SIXTH_Q      = (ONE_Q + 3) / 6;
	localparam longint unsigned TWO_THIRDS_Q = (4 * ONE_Q + 3) / 6;
	localparam int              ONE_I        = 1 << FRAC_BITS;

	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 16;      // pipeline is six deep; leave margin
	localparam int CYCLE_LIMIT  = 100000;

	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS:0]   lightness;
		logic [FRAC_BITS:0]   saturation;
	} hls_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

	logic clk;
	logic arst_n;

	hrc_in_if #(.FRAC_BITS(FRAC_BITS)) pix_in_bus ();
	hrc_out_if                         pix_out_bus ();

	hls_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in_bus),
		.pix_out(pix_out_bus)
	);

	// items still to be offered, and colors owed by the block in arrival order
	hls_t pending_hls[$];
	rgb_t rgb_expected[$];

	hls_t next_hls;
	rgb_t next_color;
	int   src_gap;
	int   src_burst;
	int   snk_stall;
	int   snk_burst;
	int   items_in;
	int   colors_out;
	int   grey_items;
	int   mismatches;
	int   cycles;

	// ---------------------------------------------------------------------
	// Color prediction
	// ---------------------------------------------------------------------

	// Locate a hue on the trapezoid: ramp up, flat top, ramp down, floor.
	function automatic hrc_pkg::seg_t hue_segment(input longint unsigned h);
		if (h < SIXTH_Q)
			return hrc_pkg::SEG_RISE;
		else if (h < HALF_Q)
			return hrc_pkg::SEG_TOP;
		else if (h < TWO_THIRDS_Q)
			return hrc_pkg::SEG_FALL;
		return hrc_pkg::SEG_BOTTOM;
	endfunction

	// Interpolate one channel between the low level m1 and the high level m2.
	function automatic longint unsigned channel_q(input longint unsigned lo,
			input longint unsigned hi, input longint unsigned hue_q);
		longint unsigned h;
		longint unsigned span;
		longint unsigned c;
		h    = hue_q & (ONE_Q - 1);
		span = hi - lo;
		case (hue_segment(h))
			hrc_pkg::SEG_RISE:   c = lo + ((span * h * 6) >> FRAC_BITS);
			hrc_pkg::SEG_TOP:    c = hi;
			hrc_pkg::SEG_FALL:   c = lo + ((span * (TWO_THIRDS_Q - h) * 6) >> FRAC_BITS);
			default:             c = lo;
		endcase
		// the rounded two-thirds bound lets the falling ramp overshoot 1.0
		if (c > ONE_Q)
			c = ONE_Q;
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] scale_byte(input longint unsigned c);
		longint unsigned v;
		v = (c * 255) >> FRAC_BITS;
		return (v > 255) ? 8'd255 : v[BYTE_W-1:0];
	endfunction

	function automatic rgb_t predict_rgb(input hls_t px);
		longint unsigned h;
		longint unsigned l;
		longint unsigned s;
		longint unsigned m1;
		longint unsigned m2;
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		rgb_t res;
		h = 64'(px.hue);
		l = 64'(px.lightness);
		s = 64'(px.saturation);
		// clip lightness and saturation to 1.0
		if (l > ONE_Q)
			l = ONE_Q;
		if (s > ONE_Q)
			s = ONE_Q;
		if (s == 0) begin
			r = l;
			g = l;
			b = l;
		end else begin
			if (l <= HALF_Q)
				m2 = (l * (ONE_Q + s)) >> FRAC_BITS;
			else
				m2 = l + s - ((l * s) >> FRAC_BITS);
			m1 = 2 * l - m2;
			r  = channel_q(m1, m2, h + THIRD_Q);
			g  = channel_q(m1, m2, h);
			b  = channel_q(m1, m2, h + ONE_Q - THIRD_Q);
		end
		res.red   = scale_byte(r);
		res.green = scale_byte(g);
		res.blue  = scale_byte(b);
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Idle pattern: mostly back to back or short, now and then long, and
	// occasional bursts with no idling at all.
	// ---------------------------------------------------------------------
	function automatic int idle_len(inout int burst);
		int r;
		if (burst > 0) begin
			burst = burst - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hls_t make_hls(input int h, input int l, input int s);
		hls_t px;
		px.hue        = h[FRAC_BITS-1:0];
		px.lightness  = l[FRAC_BITS:0];
		px.saturation = s[FRAC_BITS:0];
		return px;
	endfunction

	// Random item: full hue circle; lightness and saturation mostly in range,
	// sometimes above 1.0 (upper bit set), saturation sometimes exactly zero.
	function automatic hls_t random_hls();
		int h;
		int l;
		int s;
		int pick;
		h    = $urandom_range(0, ONE_I - 1);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			l = $urandom_range(ONE_I + 1, 2 * ONE_I - 1);
		else if (pick < 15)
			l = (pick & 1) ? 0 : ONE_I;
		else
			l = $urandom_range(0, ONE_I);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			s = $urandom_range(ONE_I + 1, 2 * ONE_I - 1);
		else if (pick < 18)
			s = 0;
		else
			s = $urandom_range(0, ONE_I);
		return make_hls(h, l, s);
	endfunction

	// ---------------------------------------------------------------------
	// Clock, reset and known values at time zero
	// ---------------------------------------------------------------------
	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		pix_in_bus.valid       = 1'b0;
		pix_in_bus.hue         = '0;
		pix_in_bus.lightness   = '0;
		pix_in_bus.saturation  = '0;
		pix_out_bus.ready      = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------------
	// Driver: predict each accepted item, then offer the next pending one
	// after its idle gap. Hold the payload while valid is high and not taken.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_in_bus.valid <= 1'b0;
			src_gap          <= 0;
		end else begin
			if (pix_in_bus.valid && pix_in_bus.ready) begin
				rgb_expected.push_back(predict_rgb({pix_in_bus.hue,
					pix_in_bus.lightness, pix_in_bus.saturation}));
				items_in = items_in + 1;
				if (pix_in_bus.saturation == 0)
					grey_items = grey_items + 1;
			end
			if (!pix_in_bus.valid || pix_in_bus.ready) begin
				if (src_gap != 0) begin
					pix_in_bus.valid <= 1'b0;
					src_gap          <= src_gap - 1;
				end else if (pending_hls.size() != 0) begin
					next_hls                = pending_hls.pop_front();
					pix_in_bus.hue          <= next_hls.hue;
					pix_in_bus.lightness    <= next_hls.lightness;
					pix_in_bus.saturation   <= next_hls.saturation;
					pix_in_bus.valid        <= 1'b1;
					src_gap                 <= idle_len(src_burst);
				end else begin
					pix_in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: check each accepted color against the oldest prediction and
	// stall the output at random.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_out_bus.ready <= 1'b0;
			snk_stall         <= 0;
		end else begin
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				colors_out = colors_out + 1;
				if (rgb_expected.size() == 0) begin
					$error("unexpected color: red %0d green %0d blue %0d",
						pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue);
					mismatches = mismatches + 1;
				end else begin
					next_color = rgb_expected.pop_front();
					if (pix_out_bus.red !== next_color.red) begin
						$error("red: expected %0d, got %0d", next_color.red, pix_out_bus.red);
						mismatches = mismatches + 1;
					end
					if (pix_out_bus.green !== next_color.green) begin
						$error("green: expected %0d, got %0d", next_color.green,
							pix_out_bus.green);
						mismatches = mismatches + 1;
					end
					if (pix_out_bus.blue !== next_color.blue) begin
						$error("blue: expected %0d, got %0d", next_color.blue,
							pix_out_bus.blue);
						mismatches = mismatches + 1;
					end
				end
			end
			if (snk_stall != 0) begin
				pix_out_bus.ready <= 1'b0;
				snk_stall         <= snk_stall - 1;
			end else begin
				pix_out_bus.ready <= 1'b1;
				snk_stall         <= idle_len(snk_burst);
			end
		end
	end

	// drop the run if the block hangs
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still owed", cycles,
				rgb_expected.size());
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		items_in   = 0;
		colors_out = 0;
		grey_items = 0;
		mismatches = 0;
		cycles     = 0;
		src_burst  = 0;
		snk_burst  = 0;

		// corners of the cube and grey
		pending_hls.push_back(make_hls(0, 0, 0));
		pending_hls.push_back(make_hls(4095, 4096, 4096));
		pending_hls.push_back(make_hls(0, 4096, 0));
		pending_hls.push_back(make_hls(1234, 2048, 0));
		// falling-ramp overshoot on green, red and blue in turn
		pending_hls.push_back(make_hls(2048, 2048, 4096));
		pending_hls.push_back(make_hls(683, 2048, 4096));
		pending_hls.push_back(make_hls(3413, 2048, 4096));
		// segment bounds on both sides, lightness on both sides of one half
		pending_hls.push_back(make_hls(682, 1000, 3000));
		pending_hls.push_back(make_hls(683, 1000, 3000));
		pending_hls.push_back(make_hls(2047, 2049, 3000));
		pending_hls.push_back(make_hls(2730, 3000, 2000));
		pending_hls.push_back(make_hls(2731, 3000, 2000));
		pending_hls.push_back(make_hls(1365, 2048, 2048));
		// lightness and saturation above one clip to one
		pending_hls.push_back(make_hls(2731, 8191, 1000));
		pending_hls.push_back(make_hls(100, 1500, 8191));
		pending_hls.push_back(make_hls(4095, 8191, 8191));
		// smallest nonzero values and near-white
		pending_hls.push_back(make_hls(0, 1, 1));
		pending_hls.push_back(make_hls(1, 4095, 4095));
		pending_hls.push_back(make_hls(3000, 2049, 4096));
		pending_hls.push_back(make_hls(2000, 2048, 1));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_hls.push_back(random_hls());

		// wait until every item is taken and every color is back
		while (pending_hls.size() != 0 || pix_in_bus.valid !== 1'b0)
			@(posedge clk);
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d HLS items (%0d grey), checked %0d colors, %0d mismatches",
			items_in, grey_items, colors_out, mismatches);
		if (mismatches == 0 && rgb_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/hrc_pkg.sv
rtl/hrc_in_if.sv
rtl/hrc_out_if.sv
rtl/hrc_level.sv
rtl/hrc_channel.sv
rtl/hls_to_rgb_converter.sv
sim/tb.sv
